[hw/rtl/aqs_pkg.sv]
// ----------------------------------------------------------------------------
// Aging ready-queue scheduler package
// Shared widths, limits, command codes and the cell control types.
// ----------------------------------------------------------------------------
package aqs_pkg;

   localparam int SCORE_W           = 10;
   localparam int TAG_W             = 8;
   localparam int DEF_QUEUE_DEPTH   = 16;
   localparam int DEF_PROGRAM_COUNT = 4;

   localparam logic [SCORE_W-1:0] SCORE_LIMIT = 10'd999;

   localparam logic CMD_ENQUEUE  = 1'b0;
   localparam logic CMD_DISPATCH = 1'b1;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT,
      CELL_ROTATE,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
      logic        found;
   } cell_ctl_type;

endpackage

[hw/rtl/aqs_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one enqueue or dispatch command.
// ----------------------------------------------------------------------------
interface aqs_req_if import aqs_pkg::*; #(
   parameter int PROG_W = 2
);
   logic                valid;
   logic                ready;
   logic                command;
   logic [PROG_W-1:0]   program_id;
   logic [SCORE_W-1:0]  start_score;
   logic [TAG_W-1:0]    entry_tag;

   modport source (output valid, command, program_id, start_score, entry_tag, input ready);
   modport sink   (input valid, command, program_id, start_score, entry_tag, output ready);
endinterface

[hw/rtl/aqs_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the result of one command.
// ----------------------------------------------------------------------------
interface aqs_rsp_if import aqs_pkg::*; #(
   parameter int PROG_W = 2
);
   logic                valid;
   logic                ready;
   logic                dispatched;
   logic [PROG_W-1:0]   out_program;
   logic [TAG_W-1:0]    out_tag;
   logic                overflow;
   logic                queue_empty;

   modport source (output valid, dispatched, out_program, out_tag, overflow, queue_empty,
                   input ready);
   modport sink   (input valid, dispatched, out_program, out_tag, overflow, queue_empty,
                   output ready);
endinterface

[hw/rtl/aging_ready_queue_scheduler_top.sv]
// ----------------------------------------------------------------------------
// Aging ready-queue scheduler
// Ordered ready queue with head dispatch, aging and program regrouping.
// ----------------------------------------------------------------------------
// The queue lives in a row of QUEUE_DEPTH cells, slot 0 being the head. An
// enqueue goes from acceptance through the done state to its response. A
// dispatch first removes the head and ages the entries of other programs as
// the cells shift; when entries remain, it then rotates the queue once past
// the head to find the lowest score, and, when regrouping is needed,
// QUEUE_DEPTH odd-even exchange passes regroup the entries by program. One
// command is in progress at a time; a response that has not been taken holds
// the next one back in the done state.
module aging_ready_queue_scheduler_top import aqs_pkg::*; #(
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
   parameter int PROGRAM_COUNT = DEF_PROGRAM_COUNT,
   parameter int PROG_W        = $clog2(PROGRAM_COUNT)
) (
   input  logic     clock,
   input  logic     reset,
   aqs_req_if.sink  req_ch,
   aqs_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = PROG_W + SCORE_W + TAG_W;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SORT, ST_DONE} state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ctr_ff, ctr_in;
   logic [PROG_W-1:0]  p_ff, p_in, q_ff, q_in;
   logic               found_ff, found_in;
   logic [SCORE_W-1:0] best_ff, best_in;
   logic               res_disp_ff, res_disp_in, res_ovf_ff, res_ovf_in;
   logic [PROG_W-1:0]  res_prog_ff, res_prog_in;
   logic [TAG_W-1:0]   res_tag_ff, res_tag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_disp_ff, rsp_disp_in, rsp_ovf_ff, rsp_ovf_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [PROG_W-1:0]  rsp_prog_ff, rsp_prog_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;

   cell_ctl_type       ctl;
   logic               accept;
   logic [EW-1:0]      ent [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic [EW-1:0]      new_entry;
   logic [PROG_W-1:0]  head_prog;
   logic [SCORE_W-1:0] head_score;
   logic [TAG_W-1:0]   head_tag;
   logic [PROG_W-1:0]  p_cell;

   assign new_entry  = {req_ch.program_id, req_ch.start_score, req_ch.entry_tag};
   assign head_prog  = ent[0][EW-1 -: PROG_W];
   assign head_score = ent[0][TAG_W +: SCORE_W];
   assign head_tag   = ent[0][TAG_W-1:0];

   // The dispatch shift compares against the head program of this cycle.
   assign p_cell = (state_ff == ST_IDLE) ? head_prog : p_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [EW-1:0] left_e, right_e;
      logic          left_v, right_v;
      assign valid_vec[i] = CW'(i) < count_ff;
      if (i > 0) begin : g_l
         assign left_e = ent[i-1];
         assign left_v = valid_vec[i-1];
      end else begin : g_nl
         assign left_e = ent[i];
         assign left_v = 1'b0;
      end
      if (i < QUEUE_DEPTH - 1) begin : g_r
         assign right_e = ent[i+1];
         assign right_v = valid_vec[i+1];
      end else begin : g_nr
         assign right_e = ent[i];
         assign right_v = 1'b0;
      end
      aqs_cell #(
         .INDEX  (i),
         .DEPTH  (QUEUE_DEPTH),
         .PROG_W (PROG_W),
         .EW     (EW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .wr_en       (count_ff == CW'(i)),
         .is_last     (count_ff == CW'(i + 1)),
         .valid       (valid_vec[i]),
         .left_valid  (left_v),
         .right_valid (right_v),
         .p_prog      (p_cell),
         .q_prog      (q_ff),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .right_entry (right_e),
         .head_entry  (ent[0]),
         .entry       (ent[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ctr_in       = ctr_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      res_disp_in  = res_disp_ff;
      res_ovf_in   = res_ovf_ff;
      res_prog_in  = res_prog_ff;
      res_tag_in   = res_tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_disp_in  = rsp_disp_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_prog_in  = rsp_prog_ff;
      rsp_tag_in   = rsp_tag_ff;
      ctl          = '{op: CELL_HOLD, phase: ctr_ff[0], found: found_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_disp_in = 1'b0;
               res_ovf_in  = 1'b0;
               res_prog_in = '0;
               res_tag_in  = '0;
               state_in    = ST_DONE;
               if (req_ch.command == CMD_ENQUEUE) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     res_ovf_in = 1'b1;
                  end else begin
                     ctl.op   = CELL_WRITE;
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff != '0) begin
                  ctl.op      = CELL_SHIFT;
                  p_in        = head_prog;
                  res_disp_in = 1'b1;
                  res_prog_in = head_prog;
                  res_tag_in  = head_tag;
                  count_in    = count_ff - CW'(1);
                  ctr_in      = '0;
                  best_in     = SCORE_LIMIT;
                  found_in    = 1'b0;
                  // The shift cannot wait for p_ff, so the head program feeds it directly.
                  if (count_ff != CW'(1)) state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ctl.op = CELL_ROTATE;
            if (head_score < best_ff) begin
               best_in  = head_score;
               q_in     = head_prog;
               found_in = 1'b1;
            end
            if (ctr_ff == count_ff - CW'(1)) begin
               ctr_in = '0;
               if (found_in && q_in == p_ff) state_in = ST_DONE;
               else                          state_in = ST_SORT;
            end else begin
               ctr_in = ctr_ff + CW'(1);
            end
         end
         ST_SORT: begin
            ctl.op = CELL_SORT;
            if (ctr_ff == CW'(QUEUE_DEPTH - 1)) state_in = ST_DONE;
            else                                ctr_in = ctr_ff + CW'(1);
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_disp_in  = res_disp_ff;
               rsp_ovf_in   = res_ovf_ff;
               rsp_prog_in  = res_prog_ff;
               rsp_tag_in   = res_tag_ff;
               rsp_empty_in = (count_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ctr_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ctr_ff       <= ctr_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff        <= p_in;
      q_ff        <= q_in;
      best_ff     <= best_in;
      res_disp_ff <= res_disp_in;
      res_ovf_ff  <= res_ovf_in;
      res_prog_ff <= res_prog_in;
      res_tag_ff  <= res_tag_in;
      rsp_disp_ff <= rsp_disp_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_prog_ff <= rsp_prog_in;
      rsp_tag_ff  <= rsp_tag_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.dispatched  = rsp_disp_ff;
   assign rsp_ch.overflow    = rsp_ovf_ff;
   assign rsp_ch.queue_empty = rsp_empty_ff;
   assign rsp_ch.out_program = rsp_prog_ff;
   assign rsp_ch.out_tag     = rsp_tag_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_disp_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.dispatched && rsp_ch.overflow))
      else $error("response both dispatched and overflowed");

   a_sort_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SORT) |-> count_ff != '0)
      else $error("scan or regroup on an empty queue");

endmodule

[hw/rtl/aqs_cell.sv]
// ----------------------------------------------------------------------------
// Queue cell
// Holds one queue slot and trades it with its neighbors on command.
// ----------------------------------------------------------------------------
module aqs_cell import aqs_pkg::*; #(
   parameter int INDEX  = 0,
   parameter int DEPTH  = DEF_QUEUE_DEPTH,
   parameter int PROG_W = 2,
   parameter int EW     = PROG_W + SCORE_W + TAG_W
) (
   input  logic              clock,
   input  cell_ctl_type      ctl,
   input  logic              wr_en,
   input  logic              is_last,
   input  logic              valid,
   input  logic              left_valid,
   input  logic              right_valid,
   input  logic [PROG_W-1:0] p_prog,
   input  logic [PROG_W-1:0] q_prog,
   input  logic [EW-1:0]     new_entry,
   input  logic [EW-1:0]     left_entry,
   input  logic [EW-1:0]     right_entry,
   input  logic [EW-1:0]     head_entry,
   output logic [EW-1:0]     entry
);

   localparam bit PARITY    = (INDEX % 2) == 1;
   localparam bit HAS_LEFT  = INDEX > 0;
   localparam bit HAS_RIGHT = INDEX < DEPTH - 1;

   logic [EW-1:0]      entry_ff, entry_in;
   logic [PROG_W-1:0]  r_prog;
   logic [SCORE_W-1:0] r_score;
   logic [TAG_W-1:0]   r_tag;
   logic [1:0]         k_left, k_self, k_right;

   // Entries of the found program sort first, of the dispatched program last of the valid ones.
   function automatic logic [1:0] sort_key(input logic v, input logic [PROG_W-1:0] pr,
                                           input logic fnd, input logic [PROG_W-1:0] p,
                                           input logic [PROG_W-1:0] q);
      logic [1:0] k;
      if (!v)                 k = 2'd3;
      else if (fnd && pr == q) k = 2'd0;
      else if (pr == p)       k = 2'd2;
      else                    k = 2'd1;
      return k;
   endfunction

   assign r_prog  = right_entry[EW-1 -: PROG_W];
   assign r_score = right_entry[TAG_W +: SCORE_W];
   assign r_tag   = right_entry[TAG_W-1:0];

   assign k_left  = sort_key(left_valid, left_entry[EW-1 -: PROG_W], ctl.found, p_prog, q_prog);
   assign k_self  = sort_key(valid, entry_ff[EW-1 -: PROG_W], ctl.found, p_prog, q_prog);
   assign k_right = sort_key(right_valid, r_prog, ctl.found, p_prog, q_prog);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctl.op)
         CELL_HOLD: ;
         CELL_WRITE: begin
            if (wr_en) entry_in = new_entry;
         end
         CELL_SHIFT: begin
            // The slot takes its right neighbor; other programs' nonzero scores age by one.
            if (r_prog != p_prog && r_score != '0) begin
               entry_in = {r_prog, r_score - SCORE_W'(1), r_tag};
            end else begin
               entry_in = right_entry;
            end
         end
         CELL_ROTATE: begin
            entry_in = is_last ? head_entry : right_entry;
         end
         CELL_SORT: begin
            if (ctl.phase == PARITY) begin
               if (HAS_RIGHT && k_self > k_right) entry_in = right_entry;
            end else begin
               if (HAS_LEFT && k_left > k_self) entry_in = left_entry;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
